FILE: rtl/core/lpt_pkg.sv
package lpt_pkg;

	localparam int OP_W   = 3;
	localparam int ADDR_W = 48;
	localparam int DATA_W = 32;
	localparam int REC_W  = 8;
	localparam int SLOT_W = 3;

	localparam logic [OP_W-1:0] OP_FIND   = 3'd0;
	localparam logic [OP_W-1:0] OP_RECENT = 3'd1;
	localparam logic [OP_W-1:0] OP_ADD    = 3'd2;
	localparam logic [OP_W-1:0] OP_READ   = 3'd3;
	localparam logic [OP_W-1:0] OP_REMOVE = 3'd4;

	localparam logic [REC_W-1:0] SEQ_TOP   = 8'hFF;
	localparam logic [REC_W-1:0] SEQ_FIRST = 8'd1;

	typedef struct packed {
		logic [OP_W-1:0]   operation;
		logic [ADDR_W-1:0] in_addr;
		logic [DATA_W-1:0] in_data;
		logic [SLOT_W-1:0] slot_index;
	} req_t;

	typedef struct packed {
		logic              found;
		logic [ADDR_W-1:0] out_addr;
		logic [DATA_W-1:0] out_data;
		logic [SLOT_W-1:0] out_slot;
	} rsp_t;

	// what the shared scan unit looks for during one pass over the slots
	typedef struct packed {
		logic match_en;
		logic free_en;
		logic best_en;
		logic best_max;
		logic thresh_en;
	} scan_ctl_t;

endpackage

FILE: rtl/core/lpt_chan_if.sv
interface lpt_chan_if #(parameter type T = logic);
	logic valid;
	logic ready;
	T     payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

FILE: rtl/core/lpt_scan_acc.sv
module lpt_scan_acc #(
	parameter int SLOTS = 8,
	localparam int IDX_W = $clog2(SLOTS)
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      clear,
	input  logic                      step,
	input  lpt_pkg::scan_ctl_t        ctl,
	input  logic [IDX_W-1:0]          idx,
	input  logic                      slot_valid,
	input  logic [lpt_pkg::ADDR_W-1:0] slot_addr,
	input  logic [lpt_pkg::ADDR_W-1:0] key,
	input  logic [lpt_pkg::REC_W-1:0]  slot_rec,
	input  logic [lpt_pkg::REC_W-1:0]  thresh,
	output logic                      hit,
	output logic [IDX_W-1:0]          hit_idx,
	output logic                      free,
	output logic [IDX_W-1:0]          free_idx,
	output logic                      best,
	output logic [IDX_W-1:0]          best_idx,
	output logic [lpt_pkg::REC_W-1:0]  best_rec
);
	import lpt_pkg::*;

	logic             hit_q, free_q, best_q;
	logic [IDX_W-1:0] hit_idx_q, free_idx_q, best_idx_q;
	logic [REC_W-1:0] best_rec_q;
	logic             rec_better, take_hit, take_free, take_best;

	always_comb begin
		rec_better = ctl.best_max ? (slot_rec > best_rec_q) : (slot_rec < best_rec_q);
		take_hit   = step && ctl.match_en && !hit_q && slot_valid && (slot_addr == key);
		take_free  = step && ctl.free_en && !free_q && !slot_valid;
		// strict compare keeps the lowest slot on ties
		take_best  = step && ctl.best_en && slot_valid
			&& (!ctl.thresh_en || (slot_rec > thresh))
			&& (!best_q || rec_better);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q  <= 1'b0;
			free_q <= 1'b0;
			best_q <= 1'b0;
		end else if (clear) begin
			hit_q  <= 1'b0;
			free_q <= 1'b0;
			best_q <= 1'b0;
		end else begin
			if (take_hit)  hit_q  <= 1'b1;
			if (take_free) free_q <= 1'b1;
			if (take_best) best_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (take_hit)  hit_idx_q  <= idx;
		if (take_free) free_idx_q <= idx;
		if (take_best) begin
			best_idx_q <= idx;
			best_rec_q <= slot_rec;
		end
	end

	assign hit      = hit_q;
	assign hit_idx  = hit_idx_q;
	assign free     = free_q;
	assign free_idx = free_idx_q;
	assign best     = best_q;
	assign best_idx = best_idx_q;
	assign best_rec = best_rec_q;

endmodule

FILE: rtl/core/lru_pairing_table_core.sv
// channel  dir  payload                                   handshake
// req      in   operation, in_addr, in_data, slot_index   valid/ready
// rsp      out  found, out_addr, out_data, out_slot       valid/ready
//
// one request at a time; find, most recent and add walk the slots through one
// memory read port and one compare unit.
// an add that finds the counter at 255 renumbers first: one walk per valid
// entry plus one final walk.
// reset clears the valid bits and the counter at once; no clearing pass.
// the result register lets the next request in while a result waits on rsp.
module lru_pairing_table_core #(
	parameter int SLOTS = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	lpt_chan_if.sink          req,
	lpt_chan_if.source        rsp
);
	import lpt_pkg::*;

	localparam int IDX_W = $clog2(SLOTS);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);
	localparam int ENT_W = ADDR_W + DATA_W;

	localparam int ST_W = 3;
	localparam logic [ST_W-1:0] ST_IDLE       = 3'd0;
	localparam logic [ST_W-1:0] ST_SCAN       = 3'd1;
	localparam logic [ST_W-1:0] ST_DECIDE     = 3'd2;
	localparam logic [ST_W-1:0] ST_FETCH      = 3'd3;
	localparam logic [ST_W-1:0] ST_FETCH_WAIT = 3'd4;
	localparam logic [ST_W-1:0] ST_COMMIT     = 3'd5;
	localparam logic [ST_W-1:0] ST_RESP       = 3'd6;

	logic [ENT_W-1:0] entry_mem [SLOTS];
	logic [REC_W-1:0] rec_mem [SLOTS];
	logic [ENT_W-1:0] entry_rd_q;
	logic [REC_W-1:0] rec_rd_q;

	logic [ST_W-1:0]   state_q;
	logic [OP_W-1:0]   op_q;
	logic              rn_q;
	logic [ADDR_W-1:0] key_q;
	logic [DATA_W-1:0] data_q;
	logic [SLOTS-1:0]  valid_q;
	logic [REC_W-1:0]  ctr_q;
	logic [REC_W-1:0]  thresh_q;
	logic [IDX_W-1:0]  rd_ptr_q;
	logic              issue_q;
	logic              scan_vld_s1;
	logic              scan_last_s1;
	logic [IDX_W-1:0]  scan_idx_s1;
	logic              res_found_q;
	logic [IDX_W-1:0]  res_idx_q;
	logic [ADDR_W-1:0] res_addr_q;
	logic [DATA_W-1:0] res_data_q;
	logic [SLOT_W-1:0] res_slot_q;
	logic              rsp_vld_q;
	rsp_t              rsp_q;

	scan_ctl_t         scan_ctl;
	logic              acc_hit, acc_free, acc_best;
	logic [IDX_W-1:0]  acc_hit_idx, acc_free_idx, acc_best_idx;
	logic [REC_W-1:0]  acc_best_rec;
	logic [IDX_W-1:0]  dest_idx;
	logic [IDX_W-1:0]  rd_addr;
	logic [IDX_W-1:0]  req_sel;
	logic              req_in_range;
	logic              entry_we, rec_we;
	logic [IDX_W-1:0]  rec_wa;

	always_comb begin
		scan_ctl.match_en  = !rn_q && ((op_q == OP_FIND) || (op_q == OP_ADD));
		scan_ctl.free_en   = !rn_q && (op_q == OP_ADD);
		scan_ctl.best_en   = rn_q || (op_q == OP_RECENT) || (op_q == OP_ADD);
		scan_ctl.best_max  = !rn_q && (op_q == OP_RECENT);
		scan_ctl.thresh_en = rn_q;
	end

	lpt_scan_acc #(.SLOTS(SLOTS)) u_scan (
		.clk        (clk),
		.arst_n     (arst_n),
		.clear      (state_q != ST_SCAN),
		.step       (scan_vld_s1),
		.ctl        (scan_ctl),
		.idx        (scan_idx_s1),
		.slot_valid (valid_q[scan_idx_s1]),
		.slot_addr  (entry_rd_q[ENT_W-1:DATA_W]),
		.key        (key_q),
		.slot_rec   (rec_rd_q),
		.thresh     (thresh_q),
		.hit        (acc_hit),
		.hit_idx    (acc_hit_idx),
		.free       (acc_free),
		.free_idx   (acc_free_idx),
		.best       (acc_best),
		.best_idx   (acc_best_idx),
		.best_rec   (acc_best_rec)
	);

	// matching entry first, then the lowest free slot, then the oldest entry
	assign dest_idx = acc_hit ? acc_hit_idx : (acc_free ? acc_free_idx : acc_best_idx);

	assign rd_addr      = (state_q == ST_FETCH) ? res_idx_q : rd_ptr_q;
	assign req_sel      = IDX_W'(req.payload.slot_index);
	assign req_in_range = int'(req.payload.slot_index) < SLOTS;

	assign entry_we = (state_q == ST_DECIDE) && !rn_q && (op_q == OP_ADD);
	assign rec_we   = (state_q == ST_COMMIT) || ((state_q == ST_DECIDE) && rn_q && acc_best);
	assign rec_wa   = (state_q == ST_COMMIT) ? res_idx_q : acc_best_idx;

	always_ff @(posedge clk) begin
		if (entry_we) entry_mem[dest_idx] <= {key_q, data_q};
		if (rec_we)   rec_mem[rec_wa] <= ctr_q + SEQ_FIRST;
		entry_rd_q <= entry_mem[rd_addr];
		rec_rd_q   <= rec_mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			op_q         <= OP_FIND;
			rn_q         <= 1'b0;
			key_q        <= '0;
			data_q       <= '0;
			valid_q      <= '0;
			ctr_q        <= '0;
			thresh_q     <= '0;
			rd_ptr_q     <= '0;
			issue_q      <= 1'b0;
			scan_vld_s1  <= 1'b0;
			scan_last_s1 <= 1'b0;
			scan_idx_s1  <= '0;
			res_found_q  <= 1'b0;
			res_idx_q    <= '0;
			res_addr_q   <= '0;
			res_data_q   <= '0;
			res_slot_q   <= '0;
			rsp_vld_q    <= 1'b0;
			rsp_q        <= '0;
		end else begin
			if (rsp_vld_q && rsp.ready && (state_q != ST_RESP)) rsp_vld_q <= 1'b0;

			unique case (state_q)
				ST_IDLE: begin
					if (req.valid) begin
						op_q        <= req.payload.operation;
						key_q       <= req.payload.in_addr;
						data_q      <= req.payload.in_data;
						rn_q        <= 1'b0;
						rd_ptr_q    <= '0;
						issue_q     <= 1'b1;
						res_found_q <= 1'b0;
						res_addr_q  <= '0;
						res_data_q  <= '0;
						res_slot_q  <= (req.payload.operation == OP_REMOVE) ?
							req.payload.slot_index : '0;
						unique case (req.payload.operation)
							OP_FIND, OP_RECENT, OP_ADD: begin
								state_q <= ST_SCAN;
							end
							OP_READ: begin
								if (req_in_range && valid_q[req_sel]) begin
									res_idx_q <= req_sel;
									state_q   <= ST_FETCH;
								end else begin
									state_q <= ST_RESP;
								end
							end
							OP_REMOVE: begin
								if (req_in_range) valid_q[req_sel] <= 1'b0;
								state_q <= ST_RESP;
							end
							default: begin
								state_q <= ST_RESP;
							end
						endcase
					end
				end
				ST_SCAN: begin
					// read issued here, compared in the next cycle in the scan unit
					if (issue_q) begin
						rd_ptr_q <= rd_ptr_q + 1'b1;
						if (rd_ptr_q == LAST_IDX) issue_q <= 1'b0;
					end
					scan_vld_s1  <= issue_q;
					scan_idx_s1  <= rd_ptr_q;
					scan_last_s1 <= (rd_ptr_q == LAST_IDX);
					if (scan_vld_s1 && scan_last_s1) state_q <= ST_DECIDE;
				end
				ST_DECIDE: begin
					if (rn_q) begin
						// next oldest entry above the last one renumbered
						if (acc_best) begin
							ctr_q    <= ctr_q + SEQ_FIRST;
							thresh_q <= acc_best_rec;
							rd_ptr_q <= '0;
							issue_q  <= 1'b1;
							state_q  <= ST_SCAN;
						end else begin
							state_q <= ST_COMMIT;
						end
					end else begin
						unique case (op_q)
							OP_FIND: begin
								if (acc_hit) begin
									res_idx_q <= acc_hit_idx;
									state_q   <= ST_FETCH;
								end else begin
									state_q <= ST_RESP;
								end
							end
							OP_RECENT: begin
								if (acc_best) begin
									res_idx_q <= acc_best_idx;
									state_q   <= ST_FETCH;
								end else begin
									state_q <= ST_RESP;
								end
							end
							OP_ADD: begin
								res_idx_q   <= dest_idx;
								res_found_q <= 1'b1;
								res_addr_q  <= key_q;
								res_data_q  <= data_q;
								res_slot_q  <= SLOT_W'(dest_idx);
								if (!acc_hit) valid_q[dest_idx] <= 1'b0;
								if (ctr_q == SEQ_TOP) begin
									rn_q     <= 1'b1;
									ctr_q    <= '0;
									thresh_q <= '0;
									rd_ptr_q <= '0;
									issue_q  <= 1'b1;
									state_q  <= ST_SCAN;
								end else begin
									state_q <= ST_COMMIT;
								end
							end
							default: begin
								state_q <= ST_RESP;
							end
						endcase
					end
				end
				ST_FETCH: begin
					state_q <= ST_FETCH_WAIT;
				end
				ST_FETCH_WAIT: begin
					res_found_q <= 1'b1;
					res_addr_q  <= entry_rd_q[ENT_W-1:DATA_W];
					res_data_q  <= entry_rd_q[DATA_W-1:0];
					res_slot_q  <= SLOT_W'(res_idx_q);
					state_q     <= ST_RESP;
				end
				ST_COMMIT: begin
					valid_q[res_idx_q] <= 1'b1;
					ctr_q              <= ctr_q + SEQ_FIRST;
					state_q            <= ST_RESP;
				end
				ST_RESP: begin
					if (!rsp_vld_q || rsp.ready) begin
						rsp_q.found    <= res_found_q;
						rsp_q.out_addr <= res_addr_q;
						rsp_q.out_data <= res_data_q;
						rsp_q.out_slot <= res_slot_q;
						rsp_vld_q      <= 1'b1;
						state_q        <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign req.ready   = (state_q == ST_IDLE);
	assign rsp.valid   = rsp_vld_q;
	assign rsp.payload = rsp_q;

endmodule
